[src/v3a_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the saturation helper for the vector3 ALU.
// No dependencies; used by every module of the block.
package v3a_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int OP_W      = 3;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int WIDE_W    = PROD_W + 2;
   localparam int SQ_W      = PROD_W;
   localparam int ROOT_W    = SQ_W / 2;
   localparam int DIV_STEPS = FRAC_BITS + 1;
   localparam int QUO_W     = FRAC_BITS + 1;
   localparam int LAT       = 3 + ROOT_W + DIV_STEPS + 1;

   localparam logic [OP_W-1:0] OP_ADD   = 3'd0;
   localparam logic [OP_W-1:0] OP_SUB   = 3'd1;
   localparam logic [OP_W-1:0] OP_CROSS = 3'd2;
   localparam logic [OP_W-1:0] OP_DOT   = 3'd3;
   localparam logic [OP_W-1:0] OP_MAG   = 3'd4;
   localparam logic [OP_W-1:0] OP_NORM  = 3'd5;

   localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;
   localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
   localparam logic signed [WIDE_W-1:0] SAT_HI = 66'sd2147483647;
   localparam logic signed [WIDE_W-1:0] SAT_LO = -66'sd2147483648;

   typedef struct packed {
      logic                     ov;
      logic signed [DATA_W-1:0] val;
   } sat_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
      logic signed [DATA_W-1:0] z;
   } vec_type;

   typedef struct packed {
      sat_type                  add;
      sat_type                  sub;
      sat_type                  crs;
      logic signed [PROD_W-1:0] dp;
      logic [PROD_W-1:0]        sq;
   } lane_out_type;

   typedef struct packed {
      logic [OP_W-1:0]          op;
      vec_type                  r;
      logic signed [DATA_W-1:0] sc;
      logic                     ov;
      vec_type                  a;
   } carry_type;

   function automatic sat_type sat32(input logic signed [WIDE_W-1:0] v);
      sat_type s;
      s.ov  = 1'b0;
      s.val = v[DATA_W-1:0];
      if (v > SAT_HI) begin
         s.ov  = 1'b1;
         s.val = Q_MAX;
      end else if (v < SAT_LO) begin
         s.ov  = 1'b1;
         s.val = Q_MIN;
      end
      return s;
   endfunction

endpackage

[src/v3a_lane.sv]
`timescale 1ns / 1ps
// One component lane: add, subtract, products and the cross term, two stages.
// Depends on v3a_pkg.
module v3a_lane (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [v3a_pkg::DATA_W-1:0] a_k,
   input  logic signed [v3a_pkg::DATA_W-1:0] b_k,
   input  logic signed [v3a_pkg::DATA_W-1:0] a_n1,
   input  logic signed [v3a_pkg::DATA_W-1:0] b_n1,
   input  logic signed [v3a_pkg::DATA_W-1:0] a_n2,
   input  logic signed [v3a_pkg::DATA_W-1:0] b_n2,
   output v3a_pkg::lane_out_type          lane_out
);

   logic signed [v3a_pkg::DATA_W:0]   sum_ff, dif_ff;
   logic signed [v3a_pkg::PROD_W-1:0] sq_ff, dp_ff, c0_ff, c1_ff;
   logic signed [v3a_pkg::PROD_W-1:0] sq_in, dp_in, c0_in, c1_in;
   logic signed [v3a_pkg::PROD_W:0]   crs_d, crs_sh;
   logic signed [v3a_pkg::WIDE_W-1:0] sum_w, dif_w, crs_w;
   v3a_pkg::lane_out_type             out_ff, out_in;

   assign sq_in = a_k * a_k;
   assign dp_in = a_k * b_k;
   assign c0_in = a_n1 * b_n2;
   assign c1_in = a_n2 * b_n1;

   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff <= {a_k[v3a_pkg::DATA_W-1], a_k} + {b_k[v3a_pkg::DATA_W-1], b_k};
         dif_ff <= {a_k[v3a_pkg::DATA_W-1], a_k} - {b_k[v3a_pkg::DATA_W-1], b_k};
         sq_ff  <= sq_in;
         dp_ff  <= dp_in;
         c0_ff  <= c0_in;
         c1_ff  <= c1_in;
      end
   end

   assign crs_d  = {c0_ff[v3a_pkg::PROD_W-1], c0_ff} - {c1_ff[v3a_pkg::PROD_W-1], c1_ff};
   assign crs_sh = crs_d >>> v3a_pkg::FRAC_BITS;
   assign sum_w  = {{(v3a_pkg::WIDE_W-v3a_pkg::DATA_W-1){sum_ff[v3a_pkg::DATA_W]}}, sum_ff};
   assign dif_w  = {{(v3a_pkg::WIDE_W-v3a_pkg::DATA_W-1){dif_ff[v3a_pkg::DATA_W]}}, dif_ff};
   assign crs_w  = {crs_sh[v3a_pkg::PROD_W], crs_sh};

   always_comb begin
      out_in.add = v3a_pkg::sat32(sum_w);
      out_in.sub = v3a_pkg::sat32(dif_w);
      out_in.crs = v3a_pkg::sat32(crs_w);
      out_in.dp  = dp_ff;
      out_in.sq  = sq_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign lane_out = out_ff;

endmodule

[src/v3a_sqrt.sv]
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per stage.
// Depends on v3a_pkg.
module v3a_sqrt (
   input  logic                         clock,
   input  logic                         en,
   input  logic [v3a_pkg::SQ_W-1:0]     sq,
   output logic [v3a_pkg::ROOT_W-1:0]   root
);

   logic [v3a_pkg::ROOT_W:0]   rem_ff  [v3a_pkg::ROOT_W];
   logic [v3a_pkg::ROOT_W-1:0] root_ff [v3a_pkg::ROOT_W];
   logic [v3a_pkg::SQ_W-1:0]   rad_ff  [v3a_pkg::ROOT_W];

   for (genvar i = 0; i < v3a_pkg::ROOT_W; i++) begin : g_stg
      logic [v3a_pkg::ROOT_W:0]   rem_prev;
      logic [v3a_pkg::ROOT_W-1:0] root_prev;
      logic [v3a_pkg::SQ_W-1:0]   rad_prev;
      logic [v3a_pkg::ROOT_W+2:0] rem_sh, trial, diff;
      logic                       ge;

      if (i == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = sq;
      end else begin : g_next
         assign rem_prev  = rem_ff[i-1];
         assign root_prev = root_ff[i-1];
         assign rad_prev  = rad_ff[i-1];
      end

      assign rem_sh = {rem_prev, rad_prev[v3a_pkg::SQ_W-1 -: 2]};
      assign trial  = {1'b0, root_prev, 2'b01};
      assign ge     = rem_sh >= trial;
      assign diff   = rem_sh - trial;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]  <= ge ? diff[v3a_pkg::ROOT_W:0] : rem_sh[v3a_pkg::ROOT_W:0];
            root_ff[i] <= {root_prev[v3a_pkg::ROOT_W-2:0], ge};
            rad_ff[i]  <= {rad_prev[v3a_pkg::SQ_W-3:0], 2'b00};
         end
      end
   end

   assign root = root_ff[v3a_pkg::ROOT_W-1];

endmodule

[src/v3a_div.sv]
`timescale 1ns / 1ps
// Pipelined restoring divider for normalize: (|v| << FRAC_BITS) / mag, signed out.
// Depends on v3a_pkg; relies on |v| <= mag.
module v3a_div (
   input  logic                             clock,
   input  logic                             en,
   input  logic [v3a_pkg::DATA_W-1:0]       dvd,
   input  logic                             neg,
   input  logic [v3a_pkg::ROOT_W-1:0]       dvs,
   output logic signed [v3a_pkg::DATA_W-1:0] quo
);

   logic [v3a_pkg::ROOT_W-1:0] rem_ff  [v3a_pkg::DIV_STEPS];
   logic [v3a_pkg::QUO_W-1:0]  quo_ff  [v3a_pkg::DIV_STEPS];
   logic [v3a_pkg::ROOT_W-1:0] dvs_ff  [v3a_pkg::DIV_STEPS];
   logic                       neg_ff  [v3a_pkg::DIV_STEPS];
   logic                       zero_ff [v3a_pkg::DIV_STEPS];

   for (genvar i = 0; i < v3a_pkg::DIV_STEPS; i++) begin : g_stg
      logic [v3a_pkg::ROOT_W:0]   rem_sh, diff;
      logic [v3a_pkg::QUO_W-1:0]  quo_prev;
      logic [v3a_pkg::ROOT_W-1:0] dvs_prev;
      logic                       neg_prev, zero_prev, ge;

      if (i == 0) begin : g_first
         assign rem_sh    = {1'b0, dvd};
         assign quo_prev  = '0;
         assign dvs_prev  = dvs;
         assign neg_prev  = neg;
         assign zero_prev = dvs == '0;
      end else begin : g_next
         assign rem_sh    = {rem_ff[i-1], 1'b0};
         assign quo_prev  = quo_ff[i-1];
         assign dvs_prev  = dvs_ff[i-1];
         assign neg_prev  = neg_ff[i-1];
         assign zero_prev = zero_ff[i-1];
      end

      assign ge   = rem_sh >= {1'b0, dvs_prev};
      assign diff = rem_sh - {1'b0, dvs_prev};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]  <= ge ? diff[v3a_pkg::ROOT_W-1:0] : rem_sh[v3a_pkg::ROOT_W-1:0];
            quo_ff[i]  <= {quo_prev[v3a_pkg::QUO_W-2:0], ge};
            dvs_ff[i]  <= dvs_prev;
            neg_ff[i]  <= neg_prev;
            zero_ff[i] <= zero_prev;
         end
      end
   end

   logic [v3a_pkg::DATA_W-1:0] q_ext;
   assign q_ext = {{(v3a_pkg::DATA_W-v3a_pkg::QUO_W){1'b0}},
                   quo_ff[v3a_pkg::DIV_STEPS-1]};

   always_comb begin
      if (zero_ff[v3a_pkg::DIV_STEPS-1]) begin
         quo = '0;
      end else if (neg_ff[v3a_pkg::DIV_STEPS-1]) begin
         quo = -$signed(q_ext);
      end else begin
         quo = $signed(q_ext);
      end
   end

endmodule

[src/vector3_alu.sv]
`timescale 1ns / 1ps
// Top level of the three-component Q16.16 vector ALU: lanes, merge, sqrt, divide.
// Depends on v3a_pkg, v3a_lane, v3a_sqrt, v3a_div.
//
//   channel  | direction | handshake          | payload
//   req      | in        | req_valid/req_stall | opcode, ax..bz
//   rsp      | out       | rsp_valid/rsp_stall | rx, ry, rz, scalar_out, overflow
//
// One beat per cycle sustained while the result is not stalled; every opcode
// runs the same path (lane products, merge, one sqrt stage per root bit, one
// divide stage per quotient bit, output register).
// Synchronous reset clears the valid pipeline only.
// A stalled result freezes the whole pipeline; req_stall follows that freeze.
module vector3_alu (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [v3a_pkg::OP_W-1:0]           req_opcode,
   input  logic signed [v3a_pkg::DATA_W-1:0]  req_ax,
   input  logic signed [v3a_pkg::DATA_W-1:0]  req_ay,
   input  logic signed [v3a_pkg::DATA_W-1:0]  req_az,
   input  logic signed [v3a_pkg::DATA_W-1:0]  req_bx,
   input  logic signed [v3a_pkg::DATA_W-1:0]  req_by_comp,
   input  logic signed [v3a_pkg::DATA_W-1:0]  req_bz,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [v3a_pkg::DATA_W-1:0]  rsp_rx,
   output logic signed [v3a_pkg::DATA_W-1:0]  rsp_ry,
   output logic signed [v3a_pkg::DATA_W-1:0]  rsp_rz,
   output logic signed [v3a_pkg::DATA_W-1:0]  rsp_scalar_out,
   output logic                               rsp_overflow
);

   logic                      en;
   logic [v3a_pkg::LAT-1:0]   vld_ff;

   logic [v3a_pkg::OP_W-1:0]  op_ab_ff [2];
   v3a_pkg::vec_type          a_ab_ff  [2];
   v3a_pkg::lane_out_type     lx, ly, lz;

   v3a_pkg::carry_type        mrg_ff, mrg_in;
   logic [v3a_pkg::SQ_W-1:0]  sq_ff, sq_in;
   logic signed [v3a_pkg::WIDE_W-1:0] dsum, dsh;
   v3a_pkg::sat_type          dsat;

   v3a_pkg::carry_type        c1_ff [v3a_pkg::ROOT_W];
   v3a_pkg::carry_type        c2_ff [v3a_pkg::DIV_STEPS];
   v3a_pkg::carry_type        c2_in, c1_last, c2_last;
   logic [v3a_pkg::ROOT_W-1:0] root;
   logic signed [v3a_pkg::DATA_W-1:0] qx, qy, qz;
   logic [v3a_pkg::DATA_W-1:0] abs_x, abs_y, abs_z;

   v3a_pkg::vec_type          r_ff, r_in;
   logic signed [v3a_pkg::DATA_W-1:0] sc_ff, sc_in;
   logic                      ov_ff, ov_in;

   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;
   assign rsp_valid = vld_ff[v3a_pkg::LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[v3a_pkg::LAT-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op_ab_ff[0] <= req_opcode;
         a_ab_ff[0]  <= '{x: req_ax, y: req_ay, z: req_az};
         op_ab_ff[1] <= op_ab_ff[0];
         a_ab_ff[1]  <= a_ab_ff[0];
      end
   end

   v3a_lane u_lane_x (
      .clock(clock), .en(en),
      .a_k(req_ax), .b_k(req_bx),
      .a_n1(req_ay), .b_n1(req_by_comp),
      .a_n2(req_az), .b_n2(req_bz),
      .lane_out(lx)
   );

   v3a_lane u_lane_y (
      .clock(clock), .en(en),
      .a_k(req_ay), .b_k(req_by_comp),
      .a_n1(req_az), .b_n1(req_bz),
      .a_n2(req_ax), .b_n2(req_bx),
      .lane_out(ly)
   );

   v3a_lane u_lane_z (
      .clock(clock), .en(en),
      .a_k(req_az), .b_k(req_bz),
      .a_n1(req_ax), .b_n1(req_bx),
      .a_n2(req_ay), .b_n2(req_by_comp),
      .lane_out(lz)
   );

   // merge: dot sum, sum of squares, per-op select
   assign dsum = {{2{lx.dp[v3a_pkg::PROD_W-1]}}, lx.dp}
               + {{2{ly.dp[v3a_pkg::PROD_W-1]}}, ly.dp}
               + {{2{lz.dp[v3a_pkg::PROD_W-1]}}, lz.dp};
   assign dsh   = dsum >>> v3a_pkg::FRAC_BITS;
   assign dsat  = v3a_pkg::sat32(dsh);
   assign sq_in = lx.sq + ly.sq + lz.sq;

   always_comb begin
      mrg_in    = '0;
      mrg_in.op = op_ab_ff[1];
      mrg_in.a  = a_ab_ff[1];
      case (op_ab_ff[1])
         v3a_pkg::OP_ADD: begin
            mrg_in.r  = '{x: lx.add.val, y: ly.add.val, z: lz.add.val};
            mrg_in.ov = lx.add.ov | ly.add.ov | lz.add.ov;
         end
         v3a_pkg::OP_SUB: begin
            mrg_in.r  = '{x: lx.sub.val, y: ly.sub.val, z: lz.sub.val};
            mrg_in.ov = lx.sub.ov | ly.sub.ov | lz.sub.ov;
         end
         v3a_pkg::OP_CROSS: begin
            mrg_in.r  = '{x: lx.crs.val, y: ly.crs.val, z: lz.crs.val};
            mrg_in.ov = lx.crs.ov | ly.crs.ov | lz.crs.ov;
         end
         v3a_pkg::OP_DOT: begin
            mrg_in.sc = dsat.val;
            mrg_in.ov = dsat.ov;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mrg_ff <= mrg_in;
         sq_ff  <= sq_in;
      end
   end

   v3a_sqrt u_sqrt (
      .clock(clock), .en(en), .sq(sq_ff), .root(root)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         c1_ff[0] <= mrg_ff;
         for (int i = 1; i < v3a_pkg::ROOT_W; i++) begin
            c1_ff[i] <= c1_ff[i-1];
         end
      end
   end

   assign c1_last = c1_ff[v3a_pkg::ROOT_W-1];

   always_comb begin
      c2_in = c1_last;
      if (c1_last.op == v3a_pkg::OP_MAG) begin
         c2_in.ov = root[v3a_pkg::ROOT_W-1];
         c2_in.sc = root[v3a_pkg::ROOT_W-1] ? v3a_pkg::Q_MAX : $signed(root);
      end
   end

   assign abs_x = c1_last.a.x[v3a_pkg::DATA_W-1] ? -c1_last.a.x : c1_last.a.x;
   assign abs_y = c1_last.a.y[v3a_pkg::DATA_W-1] ? -c1_last.a.y : c1_last.a.y;
   assign abs_z = c1_last.a.z[v3a_pkg::DATA_W-1] ? -c1_last.a.z : c1_last.a.z;

   v3a_div u_div_x (
      .clock(clock), .en(en), .dvd(abs_x),
      .neg(c1_last.a.x[v3a_pkg::DATA_W-1]), .dvs(root), .quo(qx)
   );

   v3a_div u_div_y (
      .clock(clock), .en(en), .dvd(abs_y),
      .neg(c1_last.a.y[v3a_pkg::DATA_W-1]), .dvs(root), .quo(qy)
   );

   v3a_div u_div_z (
      .clock(clock), .en(en), .dvd(abs_z),
      .neg(c1_last.a.z[v3a_pkg::DATA_W-1]), .dvs(root), .quo(qz)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         c2_ff[0] <= c2_in;
         for (int i = 1; i < v3a_pkg::DIV_STEPS; i++) begin
            c2_ff[i] <= c2_ff[i-1];
         end
      end
   end

   assign c2_last = c2_ff[v3a_pkg::DIV_STEPS-1];

   always_comb begin
      r_in  = c2_last.r;
      sc_in = c2_last.sc;
      ov_in = c2_last.ov;
      if (c2_last.op == v3a_pkg::OP_NORM) begin
         r_in  = '{x: qx, y: qy, z: qz};
         sc_in = '0;
         ov_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff  <= r_in;
         sc_ff <= sc_in;
         ov_ff <= ov_in;
      end
   end

   assign rsp_rx         = r_ff.x;
   assign rsp_ry         = r_ff.y;
   assign rsp_rz         = r_ff.z;
   assign rsp_scalar_out = sc_ff;
   assign rsp_overflow   = ov_ff;

endmodule
